### hdl/text_mode_cell_renderer_assert.svh
// Assertion macros for the text-mode cell renderer checker.
// Used by tmcr_checker; each macro expects clk and rst in scope.
`ifndef TEXT_MODE_CELL_RENDERER_ASSERT_SVH
`define TEXT_MODE_CELL_RENDERER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMCR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_mode_cell_renderer: check failed");

// The consequent must hold in the cycle after the antecedent.
`define TMCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text_mode_cell_renderer: check failed");

`endif

### hdl/tmcr_pkg.sv
// Shared types and constants for the text-mode cell renderer.
// No dependencies; used by tmcr_ctrl, tmcr_datapath, the top level and the checker.
package tmcr_pkg;

  localparam int TEXT_COLUMNS = 80;
  localparam int GLYPH_ROWS = 16;
  localparam int SCREEN_ROWS = 25;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int BYTE_W = 8;
  localparam int COLOR_W = 24;
  localparam int PALETTE_SIZE = 8;
  localparam int PAL_IDX_W = $clog2(PALETTE_SIZE);
  localparam int CFG_INDEX_W = PAL_IDX_W;
  localparam int CELL_COUNT = STORE_DEPTH / 2;
  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int GLYPH_W = $clog2(GLYPH_ROWS);
  localparam int COL_W = $clog2(TEXT_COLUMNS);
  localparam int ROW_W = $clog2(CELL_COUNT / TEXT_COLUMNS + 1);
  localparam int CURSOR_ROW_FIRST = GLYPH_ROWS - 2;
  localparam int PIXEL_X_W = 10;
  localparam int PIXEL_Y_W = 9;
  localparam int FG_LSB = 0;
  localparam int BG_LSB = 4;

  localparam int DIV_SHIFT = 18;
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + TEXT_COLUMNS - 1) / TEXT_COLUMNS;
  localparam int DIV_RECIP_W = $clog2(DIV_RECIP + 1);
  localparam int DIV_PROD_W = CELL_W + DIV_RECIP_W;

  typedef logic [COLOR_W-1:0] color_t;

  localparam color_t PALETTE_RESET [PALETTE_SIZE] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA
  };

  typedef enum logic [1:0] {
    FUNC_TEXT_WRITE = 2'd0,
    FUNC_FONT_WRITE = 2'd1,
    FUNC_RENDER     = 2'd2,
    FUNC_NONE       = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
    logic [ADDR_W-1:0] cursor_address;
    logic              cursor_on;
  } req_t;

  typedef struct packed {
    logic [PIXEL_X_W-1:0] pixel_x;
    logic [PIXEL_Y_W-1:0] pixel_y;
    color_t               color_a;
    color_t               color_b;
    color_t               color_c;
    color_t               color_d;
    color_t               color_e;
    color_t               color_f;
    color_t               color_g;
    color_t               color_h;
    logic                 last_row;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEXT,
    ST_SPLIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic text_latch;
    logic split_latch;
    logic row_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic render;
    logic on_screen;
    logic last_glyph;
  } dp_status_t;

endpackage

### hdl/tmcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/tmcr_ctrl.sv
// Controller state machine of the text-mode cell renderer.
// Depends on tmcr_pkg; drives tmcr_datapath through command signals.
module tmcr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   res_valid,
  input  logic                   res_ready,
  output tmcr_pkg::ctrl_cmd_t    cmd,
  input  tmcr_pkg::dp_status_t   status
);

  tmcr_pkg::state_t state;
  tmcr_pkg::state_t state_next;
  logic             res_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmcr_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tmcr_pkg::ST_IDLE: begin
        if (req_valid && status.render) begin
          state_next = tmcr_pkg::ST_TEXT;
        end
      end
      tmcr_pkg::ST_TEXT: begin
        state_next = tmcr_pkg::ST_SPLIT;
      end
      tmcr_pkg::ST_SPLIT: begin
        state_next = status.on_screen ? tmcr_pkg::ST_EMIT : tmcr_pkg::ST_IDLE;
      end
      tmcr_pkg::ST_EMIT: begin
        if (cmd.row_load && status.last_glyph) begin
          state_next = tmcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tmcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready        = (state == tmcr_pkg::ST_IDLE);
    cmd.capture      = req_valid && req_ready;
    cmd.text_latch   = (state == tmcr_pkg::ST_TEXT);
    cmd.split_latch  = (state == tmcr_pkg::ST_SPLIT);
    cmd.row_load     = (state == tmcr_pkg::ST_EMIT) && (!res_valid || res_ready);
    res_valid_next   = cmd.row_load || (res_valid && !res_ready);
  end

endmodule

### hdl/tmcr_datapath.sv
// Datapath of the text-mode cell renderer: stores, palette, cell math, row output.
// Depends on tmcr_pkg and tmcr_ram; controlled by tmcr_ctrl.
module tmcr_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  tmcr_pkg::req_t                     req,
  input  logic                               cfg_valid,
  input  logic [tmcr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  tmcr_pkg::color_t                   cfg_data,
  input  tmcr_pkg::ctrl_cmd_t                cmd,
  output tmcr_pkg::dp_status_t               status,
  output tmcr_pkg::res_t                     res
);

  tmcr_pkg::color_t palette [tmcr_pkg::PALETTE_SIZE];

  logic [tmcr_pkg::CELL_W-1:0]     cell_idx;
  logic                            cursor_hit;
  logic [tmcr_pkg::BYTE_W-1:0]     ch;
  logic [tmcr_pkg::BYTE_W-1:0]     attr;
  tmcr_pkg::color_t                fg;
  tmcr_pkg::color_t                bg;
  logic [tmcr_pkg::ROW_W-1:0]      row;
  logic [tmcr_pkg::COL_W-1:0]      col;
  logic [tmcr_pkg::GLYPH_W-1:0]    glyph;

  logic [tmcr_pkg::CELL_W-1:0]     req_cell;
  logic                            char_we;
  logic                            attr_we;
  logic                            font_we;
  logic [tmcr_pkg::CELL_W-1:0]     text_raddr;
  logic [tmcr_pkg::BYTE_W-1:0]     char_rdata;
  logic [tmcr_pkg::BYTE_W-1:0]     attr_rdata;
  logic [tmcr_pkg::GLYPH_W-1:0]    glyph_rd;
  logic [tmcr_pkg::ADDR_W-1:0]     font_raddr;
  logic [tmcr_pkg::BYTE_W-1:0]     font_rdata;
  logic [tmcr_pkg::PAL_IDX_W-1:0]  pal_sel;
  tmcr_pkg::color_t                pal_color;
  logic [tmcr_pkg::DIV_PROD_W-1:0] div_prod;
  logic [tmcr_pkg::CELL_W-1:0]     row_base;
  logic [tmcr_pkg::BYTE_W-1:0]     bits;

  assign req_cell   = req.address[tmcr_pkg::ADDR_W-1:1];
  assign char_we    = cmd.capture && (req.func == tmcr_pkg::FUNC_TEXT_WRITE)
                      && !req.address[0];
  assign attr_we    = cmd.capture && (req.func == tmcr_pkg::FUNC_TEXT_WRITE)
                      && req.address[0];
  assign font_we    = cmd.capture && (req.func == tmcr_pkg::FUNC_FONT_WRITE);
  assign text_raddr = cmd.capture ? req_cell : cell_idx;
  assign glyph_rd   = cmd.row_load ? glyph + tmcr_pkg::GLYPH_W'(1) : glyph;
  assign font_raddr = tmcr_pkg::ADDR_W'({ch, glyph_rd});

  tmcr_ram #(.WIDTH(tmcr_pkg::BYTE_W), .DEPTH(tmcr_pkg::CELL_COUNT)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (req_cell),
    .wdata (req.data),
    .raddr (text_raddr),
    .rdata (char_rdata)
  );

  tmcr_ram #(.WIDTH(tmcr_pkg::BYTE_W), .DEPTH(tmcr_pkg::CELL_COUNT)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (req_cell),
    .wdata (req.data),
    .raddr (text_raddr),
    .rdata (attr_rdata)
  );

  tmcr_ram #(.WIDTH(tmcr_pkg::BYTE_W), .DEPTH(tmcr_pkg::STORE_DEPTH)) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (req.address),
    .wdata (req.data),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      palette <= tmcr_pkg::PALETTE_RESET;
    end else if (cfg_valid) begin
      palette[cfg_index] <= cfg_data;
    end
  end

  // The foreground is looked up while the attribute arrives, the background in the next cycle.
  assign pal_sel   = cmd.text_latch ? attr_rdata[tmcr_pkg::FG_LSB +: tmcr_pkg::PAL_IDX_W]
                                    : attr[tmcr_pkg::BG_LSB +: tmcr_pkg::PAL_IDX_W];
  assign pal_color = palette[pal_sel];

  assign div_prod = tmcr_pkg::DIV_PROD_W'(cell_idx) * tmcr_pkg::DIV_PROD_W'(tmcr_pkg::DIV_RECIP);
  assign row_base = tmcr_pkg::CELL_W'(row * tmcr_pkg::TEXT_COLUMNS);

  assign bits = (cursor_hit && (glyph >= tmcr_pkg::GLYPH_W'(tmcr_pkg::CURSOR_ROW_FIRST)))
                ? '1 : font_rdata;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cell_idx   <= req_cell;
      cursor_hit <= req.cursor_on && ({req_cell, 1'b0} == req.cursor_address);
      glyph      <= '0;
    end
    if (cmd.text_latch) begin
      ch   <= char_rdata;
      attr <= attr_rdata;
      fg   <= pal_color;
      row  <= tmcr_pkg::ROW_W'(div_prod >> tmcr_pkg::DIV_SHIFT);
    end
    if (cmd.split_latch) begin
      bg  <= pal_color;
      col <= tmcr_pkg::COL_W'(cell_idx - row_base);
    end
    if (cmd.row_load) begin
      glyph        <= glyph + tmcr_pkg::GLYPH_W'(1);
      res.pixel_x  <= tmcr_pkg::PIXEL_X_W'({col, 3'b000});
      res.pixel_y  <= tmcr_pkg::PIXEL_Y_W'({row, glyph});
      res.color_a  <= bits[7] ? fg : bg;
      res.color_b  <= bits[6] ? fg : bg;
      res.color_c  <= bits[5] ? fg : bg;
      res.color_d  <= bits[4] ? fg : bg;
      res.color_e  <= bits[3] ? fg : bg;
      res.color_f  <= bits[2] ? fg : bg;
      res.color_g  <= bits[1] ? fg : bg;
      res.color_h  <= bits[0] ? fg : bg;
      res.last_row <= status.last_glyph;
    end
  end

  assign status.render     = (req.func == tmcr_pkg::FUNC_RENDER);
  assign status.on_screen  = (row < tmcr_pkg::ROW_W'(tmcr_pkg::SCREEN_ROWS));
  assign status.last_glyph = (glyph == tmcr_pkg::GLYPH_W'(tmcr_pkg::GLYPH_ROWS - 1));

endmodule

### hdl/text_mode_cell_renderer.sv
// Top level of the text-mode cell renderer.
// Depends on tmcr_pkg, tmcr_ctrl, tmcr_datapath and tmcr_ram.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------
//   req     | req_valid, req_ready  | req (func, address, data, cursor)
//   res     | res_valid, res_ready  | res (pixel_x, pixel_y, colors, last_row)
//   cfg     | cfg_valid, cfg_ready  | cfg_index, cfg_data (palette entry)
//
// A write is done once taken; func 3 and off-screen cells produce nothing.
// A render request does text lookup and row/column math, then 16 rows at one
// row per cycle unless res stalls, a rate set by the font RAM's single read port.
// A stalled res channel holds the row counter; the last row may wait in the
// output register while the next request is taken. Reset is synchronous and
// restores the palette; the RAMs need no clearing pass.
module text_mode_cell_renderer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  tmcr_pkg::req_t                   req,
  output logic                             res_valid,
  input  logic                             res_ready,
  output tmcr_pkg::res_t                   res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tmcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  tmcr_pkg::color_t                 cfg_data
);

  tmcr_pkg::ctrl_cmd_t  cmd;
  tmcr_pkg::dp_status_t status;
  logic                 cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  tmcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cmd       (cmd),
    .status    (status)
  );

  tmcr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .res       (res)
  );

endmodule

### hdl/tmcr_checker.sv
// Port-level checks for the text-mode cell renderer, bound to the top level.
// Depends on tmcr_pkg and text_mode_cell_renderer_assert.svh.
`include "text_mode_cell_renderer_assert.svh"

module tmcr_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           res_valid,
  input logic           res_ready,
  input tmcr_pkg::res_t res
);

  `TMCR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
  `TMCR_ASSERT_SAME(a_last_row_pos, res_valid, res.last_row == (res.pixel_y[3:0] == 4'hF))
  `TMCR_ASSERT_SAME(a_busy_mid_cell, res_valid && !res.last_row, !req_ready)
  `TMCR_ASSERT_SAME(a_on_screen, res_valid, (res.pixel_x < 10'd640) && (res.pixel_y < 9'd400))

endmodule

bind text_mode_cell_renderer tmcr_checker u_checker (.*);

### tb/text_mode_cell_renderer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text-mode cell renderer: it fills the text and
// font stores, renders cells under several palettes and checks every glyph row.
// Depends on tmcr_pkg and the text_mode_cell_renderer top level.
module text_mode_cell_renderer_tb;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PRESSURE_RENDERS = 6;

  typedef enum int {PAL_RANDOM, PAL_ZERO, PAL_FULL, PAL_STRIPED} palette_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  tmcr_pkg::req_t req;
  logic res_valid;
  logic res_ready;
  tmcr_pkg::res_t res;
  logic cfg_valid;
  logic cfg_ready;
  logic [tmcr_pkg::CFG_INDEX_W-1:0] cfg_index;
  tmcr_pkg::color_t cfg_data;

  tmcr_pkg::color_t palette_now [tmcr_pkg::PALETTE_SIZE];
  logic [tmcr_pkg::BYTE_W-1:0] text_copy [tmcr_pkg::STORE_DEPTH];
  logic [tmcr_pkg::BYTE_W-1:0] font_copy [tmcr_pkg::STORE_DEPTH];
  bit text_written [tmcr_pkg::STORE_DEPTH];
  bit font_written [tmcr_pkg::STORE_DEPTH];
  logic [tmcr_pkg::BYTE_W-1:0] glyph_list [$];
  int touched_cells [$];
  tmcr_pkg::res_t expected_rows [$];
  tmcr_pkg::res_t oldest_row;

  bit idling_on = 1'b1;
  int result_holdoff = 0;
  int counted_items = 0;
  int renders_sent = 0;
  int rows_checked = 0;
  int palette_writes = 0;
  int failures = 0;

  text_mode_cell_renderer dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("text_mode_cell_renderer_tb: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idling_on || roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic tmcr_pkg::req_t make_req(tmcr_pkg::func_t f,
                                              logic [tmcr_pkg::ADDR_W-1:0] a,
                                              logic [tmcr_pkg::BYTE_W-1:0] d,
                                              logic [tmcr_pkg::ADDR_W-1:0] ca, logic co);
    tmcr_pkg::req_t r;
    r.func = f;
    r.address = a;
    r.data = d;
    r.cursor_address = ca;
    r.cursor_on = co;
    return r;
  endfunction

  function automatic tmcr_pkg::color_t color_of(tmcr_pkg::res_t r, int k);
    case (k)
      0: return r.color_a;
      1: return r.color_b;
      2: return r.color_c;
      3: return r.color_d;
      4: return r.color_e;
      5: return r.color_f;
      6: return r.color_g;
      default: return r.color_h;
    endcase
  endfunction

  function automatic bit glyph_ready(logic [tmcr_pkg::BYTE_W-1:0] ch);
    for (int i = 0; i < tmcr_pkg::GLYPH_ROWS; i++) begin
      if (!font_written[{ch, tmcr_pkg::GLYPH_W'(i)}]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit cell_drawable(int cell_no);
    logic [tmcr_pkg::ADDR_W-1:0] a;
    a = tmcr_pkg::ADDR_W'(cell_no * 2);
    return text_written[a] && text_written[a | tmcr_pkg::ADDR_W'(1)]
           && glyph_ready(text_copy[a]);
  endfunction

  // Updates the store mirrors and queues the sixteen rows that an on-screen render produces.
  function automatic void predict_request(tmcr_pkg::req_t r);
    logic [tmcr_pkg::ADDR_W-1:0] cell_addr;
    int cell_no;
    int col;
    int text_row;
    logic [tmcr_pkg::BYTE_W-1:0] ch;
    logic [tmcr_pkg::BYTE_W-1:0] attr;
    logic [tmcr_pkg::BYTE_W-1:0] bits;
    tmcr_pkg::color_t fg;
    tmcr_pkg::color_t bg;
    tmcr_pkg::color_t px [8];
    logic at_cursor;
    tmcr_pkg::res_t row;
    case (r.func)
      tmcr_pkg::FUNC_TEXT_WRITE: begin
        text_copy[r.address] = r.data;
        text_written[r.address] = 1'b1;
      end
      tmcr_pkg::FUNC_FONT_WRITE: begin
        font_copy[r.address] = r.data;
        font_written[r.address] = 1'b1;
      end
      tmcr_pkg::FUNC_RENDER: begin
        cell_addr = {r.address[tmcr_pkg::ADDR_W-1:1], 1'b0};
        cell_no = int'(cell_addr) / 2;
        col = cell_no % tmcr_pkg::TEXT_COLUMNS;
        text_row = cell_no / tmcr_pkg::TEXT_COLUMNS;
        if (text_row < tmcr_pkg::SCREEN_ROWS) begin
          ch = text_copy[cell_addr];
          attr = text_copy[{r.address[tmcr_pkg::ADDR_W-1:1], 1'b1}];
          fg = palette_now[attr[tmcr_pkg::FG_LSB +: tmcr_pkg::PAL_IDX_W]];
          bg = palette_now[attr[tmcr_pkg::BG_LSB +: tmcr_pkg::PAL_IDX_W]];
          at_cursor = (r.cursor_address == cell_addr) && r.cursor_on;
          for (int i = 0; i < tmcr_pkg::GLYPH_ROWS; i++) begin
            bits = font_copy[{ch, tmcr_pkg::GLYPH_W'(i)}];
            if (at_cursor && i >= tmcr_pkg::CURSOR_ROW_FIRST) begin
              bits = '1;
            end
            for (int j = 0; j < 8; j++) begin
              px[j] = bits[7 - j] ? fg : bg;
            end
            row.pixel_x = tmcr_pkg::PIXEL_X_W'(col * 8);
            row.pixel_y = tmcr_pkg::PIXEL_Y_W'(text_row * tmcr_pkg::GLYPH_ROWS + i);
            row.color_a = px[0];
            row.color_b = px[1];
            row.color_c = px[2];
            row.color_d = px[3];
            row.color_e = px[4];
            row.color_f = px[5];
            row.color_g = px[6];
            row.color_h = px[7];
            row.last_row = (i == tmcr_pkg::GLYPH_ROWS - 1);
            expected_rows.push_back(row);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_row(input tmcr_pkg::res_t want, input tmcr_pkg::res_t got);
    if (got.pixel_x !== want.pixel_x) begin
      $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
      failures++;
    end
    if (got.pixel_y !== want.pixel_y) begin
      $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
      failures++;
    end
    for (int k = 0; k < 8; k++) begin
      if (color_of(got, k) !== color_of(want, k)) begin
        $error("color_%c: expected %06h, got %06h", byte'(8'h61 + k),
               color_of(want, k), color_of(got, k));
        failures++;
      end
    end
    if (got.last_row !== want.last_row) begin
      $error("last_row: expected %0b, got %0b", want.last_row, got.last_row);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_rows.size() == 0) begin
        $error("row result at x %0d, y %0d with no row expected", res.pixel_x, res.pixel_y);
        failures++;
      end else begin
        oldest_row = expected_rows.pop_front();
        check_row(oldest_row, res);
        rows_checked++;
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (result_holdoff > 0) begin
        res_ready <= 1'b0;
        result_holdoff--;
      end else if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else begin
        res_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic issue_request(input tmcr_pkg::req_t r);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_request(r);
    if (r.func != tmcr_pkg::FUNC_NONE) begin
      counted_items++;
    end
    if (r.func == tmcr_pkg::FUNC_RENDER) begin
      renders_sent++;
    end
  endtask

  task automatic settle_block();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_palette(input int k, input tmcr_pkg::color_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= tmcr_pkg::CFG_INDEX_W'(k);
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    palette_now[k] = value;
    palette_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_cell(input int cell_no, input logic [tmcr_pkg::BYTE_W-1:0] ch,
                            input logic [tmcr_pkg::BYTE_W-1:0] attr);
    issue_request(make_req(tmcr_pkg::FUNC_TEXT_WRITE, tmcr_pkg::ADDR_W'(cell_no * 2), ch,
                           tmcr_pkg::ADDR_W'($urandom), 1'($urandom)));
    issue_request(make_req(tmcr_pkg::FUNC_TEXT_WRITE, tmcr_pkg::ADDR_W'(cell_no * 2 + 1),
                           attr, tmcr_pkg::ADDR_W'($urandom), 1'($urandom)));
    touched_cells.push_back(cell_no);
  endtask

  task automatic load_glyph(input logic [tmcr_pkg::BYTE_W-1:0] ch);
    for (int i = 0; i < tmcr_pkg::GLYPH_ROWS; i++) begin
      issue_request(make_req(tmcr_pkg::FUNC_FONT_WRITE, {ch, tmcr_pkg::GLYPH_W'(i)},
                             tmcr_pkg::BYTE_W'($urandom), tmcr_pkg::ADDR_W'($urandom),
                             1'($urandom)));
    end
    glyph_list.push_back(ch);
  endtask

  task automatic render_cell(input int cell_no);
    logic [tmcr_pkg::ADDR_W-1:0] a;
    logic [tmcr_pkg::ADDR_W-1:0] cur;
    logic on;
    a = tmcr_pkg::ADDR_W'(cell_no * 2);
    case ($urandom_range(0, 3))
      0: begin
        cur = a;
        on = 1'b1;
      end
      1: begin
        cur = a;
        on = 1'b0;
      end
      2: begin
        cur = a | tmcr_pkg::ADDR_W'(1);
        on = 1'b1;
      end
      default: begin
        cur = tmcr_pkg::ADDR_W'($urandom);
        on = 1'($urandom);
      end
    endcase
    issue_request(make_req(tmcr_pkg::FUNC_RENDER, a | tmcr_pkg::ADDR_W'($urandom_range(0, 1)),
                           tmcr_pkg::BYTE_W'($urandom), cur, on));
  endtask

  task automatic render_random_cell();
    int cell_no;
    if (touched_cells.size() != 0 && $urandom_range(0, 99) < 85) begin
      cell_no = touched_cells[$urandom_range(0, touched_cells.size() - 1)];
    end else begin
      cell_no = $urandom_range(0, tmcr_pkg::CELL_COUNT - 1);
    end
    if (!cell_drawable(cell_no)) begin
      write_cell(cell_no, glyph_list[$urandom_range(0, glyph_list.size() - 1)],
                 tmcr_pkg::BYTE_W'($urandom));
    end
    render_cell(cell_no);
  endtask

  task automatic test_glyph_and_text_setup();
    logic [tmcr_pkg::BYTE_W-1:0] patterns [6];
    patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
    for (int i = 0; i < tmcr_pkg::GLYPH_ROWS; i++) begin
      issue_request(make_req(tmcr_pkg::FUNC_FONT_WRITE, {8'hFF, tmcr_pkg::GLYPH_W'(i)},
                             (i < 6) ? patterns[i] : tmcr_pkg::BYTE_W'($urandom), '0,
                             1'b0));
    end
    glyph_list.push_back(8'hFF);
    write_cell(0, 8'hFF, 8'h70);
    write_cell(tmcr_pkg::TEXT_COLUMNS * tmcr_pkg::SCREEN_ROWS - 1, 8'hFF, 8'h8F);
    write_cell(tmcr_pkg::TEXT_COLUMNS * tmcr_pkg::SCREEN_ROWS, 8'hFF, 8'h12);
    write_cell(tmcr_pkg::CELL_COUNT - 1, 8'hFF, 8'hFF);
  endtask

  task automatic test_render_corners();
    logic [tmcr_pkg::ADDR_W-1:0] last_on;
    last_on = tmcr_pkg::ADDR_W'((tmcr_pkg::TEXT_COLUMNS * tmcr_pkg::SCREEN_ROWS - 1) * 2);
    issue_request(make_req(tmcr_pkg::FUNC_RENDER, '0, 8'hFF, '0, 1'b1));
    issue_request(make_req(tmcr_pkg::FUNC_RENDER, tmcr_pkg::ADDR_W'(1), 8'h00,
                           tmcr_pkg::ADDR_W'(1), 1'b1));
    issue_request(make_req(tmcr_pkg::FUNC_RENDER, last_on | tmcr_pkg::ADDR_W'(1), 8'h5A,
                           last_on, 1'b0));
    issue_request(make_req(tmcr_pkg::FUNC_RENDER, last_on, 8'hA5, last_on, 1'b1));
    issue_request(make_req(tmcr_pkg::FUNC_RENDER, last_on + tmcr_pkg::ADDR_W'(2), 8'h00,
                           last_on + tmcr_pkg::ADDR_W'(2), 1'b1));
    issue_request(make_req(tmcr_pkg::FUNC_RENDER, '1, 8'hFF, '1, 1'b1));
  endtask

  task automatic test_unused_function();
    issue_request(make_req(tmcr_pkg::FUNC_NONE, tmcr_pkg::ADDR_W'($urandom),
                           tmcr_pkg::BYTE_W'($urandom), tmcr_pkg::ADDR_W'($urandom),
                           1'($urandom)));
    render_cell(0);
  endtask

  task automatic test_palette_phase(input palette_mode_t mode);
    tmcr_pkg::color_t value;
    settle_block();
    for (int k = 0; k < tmcr_pkg::PALETTE_SIZE; k++) begin
      case (mode)
        PAL_ZERO: value = '0;
        PAL_FULL: value = '1;
        PAL_STRIPED: value = k[0] ? '1 : '0;
        default: value = tmcr_pkg::COLOR_W'($urandom);
      endcase
      write_palette(k, value);
    end
  endtask

  task automatic test_random_traffic(input int count);
    int start;
    int pick;
    start = counted_items;
    if (!glyph_ready(8'h00)) begin
      load_glyph(8'h00);
    end
    while (counted_items - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        render_random_cell();
      end else if (pick < 65) begin
        write_cell($urandom_range(0, tmcr_pkg::CELL_COUNT - 1),
                   ($urandom_range(0, 3) == 0) ? tmcr_pkg::BYTE_W'($urandom) :
                   glyph_list[$urandom_range(0, glyph_list.size() - 1)],
                   tmcr_pkg::BYTE_W'($urandom));
      end else if (pick < 75) begin
        issue_request(make_req(tmcr_pkg::FUNC_FONT_WRITE,
                               {glyph_list[$urandom_range(0, glyph_list.size() - 1)],
                                tmcr_pkg::GLYPH_W'($urandom)},
                               tmcr_pkg::BYTE_W'($urandom), tmcr_pkg::ADDR_W'($urandom),
                               1'($urandom)));
      end else if (pick < 83) begin
        issue_request(make_req(tmcr_pkg::FUNC_TEXT_WRITE, tmcr_pkg::ADDR_W'($urandom),
                               tmcr_pkg::BYTE_W'($urandom), tmcr_pkg::ADDR_W'($urandom),
                               1'($urandom)));
      end else if (pick < 88) begin
        issue_request(make_req(tmcr_pkg::FUNC_FONT_WRITE, tmcr_pkg::ADDR_W'($urandom),
                               tmcr_pkg::BYTE_W'($urandom), tmcr_pkg::ADDR_W'($urandom),
                               1'($urandom)));
      end else if (pick < 93) begin
        load_glyph(tmcr_pkg::BYTE_W'($urandom));
      end else begin
        issue_request(make_req(tmcr_pkg::FUNC_NONE, tmcr_pkg::ADDR_W'($urandom),
                               tmcr_pkg::BYTE_W'($urandom), tmcr_pkg::ADDR_W'($urandom),
                               1'($urandom)));
      end
    end
  endtask

  task automatic test_output_backpressure();
    settle_block();
    idling_on = 1'b0;
    result_holdoff = HOLDOFF_CYCLES;
    for (int i = 0; i < PRESSURE_RENDERS; i++) begin
      render_random_cell();
    end
    settle_block();
    idling_on = 1'b1;
  endtask

  initial begin
    for (int k = 0; k < tmcr_pkg::PALETTE_SIZE; k++) begin
      palette_now[k] = tmcr_pkg::PALETTE_RESET[k];
    end
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_glyph_and_text_setup();
    test_render_corners();
    test_unused_function();
    test_palette_phase(PAL_RANDOM);
    test_random_traffic(20);
    test_palette_phase(PAL_ZERO);
    test_random_traffic(8);
    test_palette_phase(PAL_FULL);
    idling_on = 1'b0;
    test_random_traffic(10);
    idling_on = 1'b1;
    test_palette_phase(PAL_STRIPED);
    test_random_traffic(12);
    test_output_backpressure();
    test_palette_phase(PAL_RANDOM);
    test_random_traffic(22);
    settle_block();

    $display("summary: %0d requests, %0d renders, %0d glyph rows checked",
             counted_items, renders_sent, rows_checked);
    $display("summary: %0d palette writes over five palette settings, %0d glyphs loaded",
             palette_writes, glyph_list.size());
    if (failures == 0) begin
      $display("text_mode_cell_renderer_tb: done, clean");
    end else begin
      $display("text_mode_cell_renderer_tb: done, errors");
    end
    $finish;
  end

endmodule
